>>> rtl/core/hdlcr_pkg.sv
// ----------------------------------------------------------------------------
// hdlcr_pkg
// Constants, result codes and the CRC byte fold for the HDLC NRZI receiver.
// ----------------------------------------------------------------------------
package hdlcr_pkg;

    localparam int MAX_FRAME_BYTES = 1024;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int FRAME_W         = 11;
    localparam int MIN_W           = 11;
    localparam int PADDR_W         = 3;

    localparam logic [7:0]  FLAG_PATTERN  = 8'h7E;
    localparam logic [7:0]  ABORT_PATTERN = 8'h7F;
    localparam logic [7:0]  STUFF_MASK    = 8'h3F;
    localparam logic [7:0]  STUFF_PATTERN = 8'h3E;
    localparam logic [15:0] CRC_POLY      = 16'h8408;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_RESIDUE   = 16'hF0B8;
    localparam logic [MIN_W-1:0] MIN_FRAME_RESET = 11'd3;

    localparam logic REG_MIN_FRAME_BYTES = 1'b0;

    localparam logic KIND_DATA      = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    localparam logic [1:0] STATUS_CRC_GOOD  = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERROR = 2'd1;
    localparam logic [1:0] STATUS_DISCARDED = 2'd2;
    localparam logic [1:0] STATUS_ABORTED   = 2'd3;

    typedef struct packed {
        logic                 kind;
        logic [7:0]           data_byte;
        logic [1:0]           frame_status;
        logic [FRAME_W-1:0]   frame_bytes;
    } t_result;

    // Reflected CRC-16 folded over one byte, LSB first.
    function automatic logic [15:0] crc_fold_byte(input logic [15:0] crc_in,
                                                  input logic [7:0] data);
        logic [15:0] crc;
        logic        fb;
        crc = crc_in;
        for (int i = 0; i < 8; i++) begin
            fb  = crc[0] ^ data[i];
            crc = {1'b0, crc[15:1]};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

>>> rtl/core/hdlc_nrzi_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// hdlc_nrzi_frame_receiver_core
// NRZI decode, flag/abort detection, bit destuffing, byte assembly and CRC-16
// check of HDLC frames, one raw line bit per input item.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_line_bit
// result    out        o_out_valid / i_out_ready    o_kind, o_data_byte,
//                                                   o_frame_status, o_frame_bytes
// config    in         APB psel/penable/pwrite      paddr, pwdata, prdata
//
// One line bit is accepted per cycle; its state update is done in the same
// cycle and any result lands in the output register at that edge.
// The output register is the only stall point: a new bit is taken whenever it
// is empty or being drained in the same cycle.
// Reset is synchronous and active low; the receiver comes up searching for a
// flag with min_frame_bytes at 3.
// ----------------------------------------------------------------------------
module hdlc_nrzi_frame_receiver_core
    import hdlcr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_line_bit,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_kind,
    output logic [7:0]           o_data_byte,
    output logic [1:0]           o_frame_status,
    output logic [FRAME_W-1:0]   o_frame_bytes,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [MIN_W-1:0] r_min_frame;

    logic             r_prev_level, n_prev_level;
    logic [7:0]       r_window,     n_window;
    logic             r_in_sync,    n_in_sync;
    logic [2:0]       r_bit_pos,    n_bit_pos;
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [7:0]       r_assembly,   n_assembly;
    logic [15:0]      r_crc,        n_crc;
    logic             r_overflow,   n_overflow;

    logic             r_out_valid;
    t_result          r_out;
    t_result          res;
    logic             res_valid;

    logic             in_accept;
    logic             d_bit;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign prdata    = 32'(r_min_frame);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_frame <= MIN_FRAME_RESET;
        end else if (cfg_write && paddr[2] == REG_MIN_FRAME_BYTES) begin
            r_min_frame <= pwdata[MIN_W-1:0];
        end
    end

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign d_bit      = (i_line_bit == r_prev_level);

    always_comb begin
        n_prev_level = i_line_bit;
        n_window     = {r_window[6:0], d_bit};
        n_in_sync    = r_in_sync;
        n_bit_pos    = r_bit_pos;
        n_byte_count = r_byte_count;
        n_assembly   = r_assembly;
        n_crc        = r_crc;
        n_overflow   = r_overflow;
        res_valid    = 1'b0;
        res          = '0;

        if (n_window == FLAG_PATTERN || n_window == ABORT_PATTERN) begin
            // A frame end is reported only for frames that carried something.
            if (r_in_sync && (r_byte_count != '0 || r_overflow)) begin
                res_valid       = 1'b1;
                res.kind        = KIND_FRAME_END;
                res.frame_bytes = FRAME_W'(r_byte_count);
                if (n_window == ABORT_PATTERN) begin
                    res.frame_status = STATUS_ABORTED;
                end else if (!r_overflow && r_bit_pos == 3'd7 &&
                             32'(r_byte_count) >= 32'(r_min_frame)) begin
                    res.frame_status = (r_crc == CRC_RESIDUE) ? STATUS_CRC_GOOD
                                                              : STATUS_CRC_ERROR;
                end else begin
                    res.frame_status = STATUS_DISCARDED;
                end
            end
            n_in_sync    = (n_window == FLAG_PATTERN);
            n_bit_pos    = '0;
            n_byte_count = '0;
            n_assembly   = '0;
            n_crc        = CRC_INIT;
            n_overflow   = 1'b0;
        end else if (r_in_sync && (n_window & STUFF_MASK) != STUFF_PATTERN) begin
            n_assembly            = r_assembly;
            n_assembly[r_bit_pos] = d_bit;
            n_bit_pos             = r_bit_pos + 3'd1;
            if (r_bit_pos == 3'd7) begin
                if (32'(r_byte_count) < MAX_FRAME_BYTES) begin
                    n_byte_count  = r_byte_count + CNT_W'(1);
                    n_crc         = crc_fold_byte(r_crc, n_assembly);
                    res_valid     = 1'b1;
                    res.kind      = KIND_DATA;
                    res.data_byte = n_assembly;
                end else begin
                    n_overflow = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b0;
            r_window     <= '0;
            r_in_sync    <= 1'b0;
            r_bit_pos    <= '0;
            r_byte_count <= '0;
            r_assembly   <= '0;
            r_crc        <= CRC_INIT;
            r_overflow   <= 1'b0;
        end else if (in_accept) begin
            r_prev_level <= n_prev_level;
            r_window     <= n_window;
            r_in_sync    <= n_in_sync;
            r_bit_pos    <= n_bit_pos;
            r_byte_count <= n_byte_count;
            r_assembly   <= n_assembly;
            r_crc        <= n_crc;
            r_overflow   <= n_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_data_byte    = r_out.data_byte;
    assign o_frame_status = r_out.frame_status;
    assign o_frame_bytes  = r_out.frame_bytes;

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_byte_count) <= MAX_FRAME_BYTES)
        else $error("byte count passed the frame limit");

    a_flag_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_window == FLAG_PATTERN) |=>
            (r_in_sync && r_bit_pos == 3'd0 && r_byte_count == '0 && !r_overflow))
        else $error("flag did not restart the frame");

    a_abort_searches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_window == ABORT_PATTERN) |=> !r_in_sync)
        else $error("abort left the receiver in sync");

    a_data_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_DATA) |->
            (r_out.frame_status == STATUS_CRC_GOOD && r_out.frame_bytes == '0))
        else $error("data byte carries frame-end fields");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_FRAME_END) |-> (r_out.data_byte == 8'd0))
        else $error("frame end carries a data byte");

    a_no_result_searching: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && res_valid) |-> r_in_sync)
        else $error("result produced while searching");

endmodule

>>> test/hdlc_nrzi_frame_receiver_core_tb.sv
// ----------------------------------------------------------------------------
// hdlc_nrzi_frame_receiver_core_tb
// Feeds the receiver an NRZI line built from HDLC frames: good frames, frames
// with a corrupted FCS, misaligned tails, short, aborted and oversized frames,
// idle flags and line noise. The generator does the bit stuffing and appends
// the FCS. A scoreboard predicts every data byte and frame end from the raw
// line levels and compares each result that leaves the block.
// ----------------------------------------------------------------------------
module hdlc_nrzi_frame_receiver_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hdlcr_pkg::*;

    localparam int REG_UNUSED = 1;

    typedef logic [7:0] t_byte_q[$];
    typedef enum int {
        SHAPE_GOOD,
        SHAPE_BAD_FCS,
        SHAPE_ODD_TAIL,
        SHAPE_NO_FCS,
        SHAPE_ABORT
    } t_frame_shape;

    // Tracks the receiver state from the raw line and queues the results it
    // should produce.
    class t_rx_scoreboard;
        logic [MIN_W-1:0] min_bytes;
        logic             prev_level;
        logic [7:0]       window;
        bit               in_sync;
        logic [2:0]       bit_pos;
        int               byte_cnt;
        logic [7:0]       assembly;
        logic [15:0]      crc;
        bit               overflow;
        t_result          pending_results[$];
        int               errors;

        function new();
            min_bytes  = MIN_FRAME_RESET;
            prev_level = 1'b0;
            window     = 8'h00;
            in_sync    = 1'b0;
            errors     = 0;
            restart_frame();
        endfunction

        static function logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] value);
            logic [15:0] c;
            c = crc_in;
            for (int i = 0; i < 8; i++) begin
                if (c[0] ^ value[i]) begin
                    c = (c >> 1) ^ CRC_POLY;
                end else begin
                    c = c >> 1;
                end
            end
            return c;
        endfunction

        function void restart_frame();
            bit_pos  = 3'd0;
            byte_cnt = 0;
            assembly = 8'h00;
            crc      = CRC_INIT;
            overflow = 1'b0;
        endfunction

        function void write_register(int index, logic [31:0] value);
            if (index == REG_MIN_FRAME_BYTES) begin
                min_bytes = value[MIN_W-1:0];
            end
        endfunction

        function t_result frame_end(logic [1:0] status);
            t_result r;
            r.kind         = KIND_FRAME_END;
            r.data_byte    = 8'h00;
            r.frame_status = status;
            r.frame_bytes  = FRAME_W'(byte_cnt);
            return r;
        endfunction

        function void take_line_bit(logic level);
            logic    d;
            t_result r;
            d          = (level == prev_level);
            prev_level = level;
            window     = {window[6:0], d};
            if (window == FLAG_PATTERN) begin
                if (in_sync && (byte_cnt > 0 || overflow)) begin
                    if (!overflow && bit_pos == 3'd7 && byte_cnt >= int'(min_bytes)) begin
                        r = frame_end((crc == CRC_RESIDUE) ? STATUS_CRC_GOOD
                                                           : STATUS_CRC_ERROR);
                    end else begin
                        r = frame_end(STATUS_DISCARDED);
                    end
                    pending_results.push_back(r);
                end
                in_sync = 1'b1;
                restart_frame();
            end else if (window == ABORT_PATTERN) begin
                if (in_sync && (byte_cnt > 0 || overflow)) begin
                    pending_results.push_back(frame_end(STATUS_ABORTED));
                end
                in_sync = 1'b0;
                restart_frame();
            end else if (in_sync && (window & STUFF_MASK) != STUFF_PATTERN) begin
                // Bits that are not a stuffed zero go into the byte, LSB first.
                assembly[bit_pos] = d;
                bit_pos = bit_pos + 3'd1;
                if (bit_pos == 3'd0) begin
                    if (byte_cnt < MAX_FRAME_BYTES) begin
                        byte_cnt++;
                        crc         = crc_byte(crc, assembly);
                        r           = '0;
                        r.kind      = KIND_DATA;
                        r.data_byte = assembly;
                        pending_results.push_back(r);
                    end else begin
                        overflow = 1'b1;
                    end
                end
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= 50) begin
                $display("mismatch at %0t: %s", $realtime, what);
            end
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result kind %0d byte %02h status %0d count %0d",
                                 got.kind, got.data_byte, got.frame_status,
                                 got.frame_bytes));
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind) begin
                    report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
                end
                if (got.data_byte !== want.data_byte) begin
                    report($sformatf("data_byte %02h, expected %02h",
                                     got.data_byte, want.data_byte));
                end
                if (got.frame_status !== want.frame_status) begin
                    report($sformatf("frame_status %0d, expected %0d",
                                     got.frame_status, want.frame_status));
                end
                if (got.frame_bytes !== want.frame_bytes) begin
                    report($sformatf("frame_bytes %0d, expected %0d",
                                     got.frame_bytes, want.frame_bytes));
                end
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               rst_n;
    logic               line_valid;
    logic               in_ready;
    logic               line_bit;
    logic               out_valid;
    logic               res_ready = 1'b0;
    logic               res_kind;
    logic [7:0]         res_byte;
    logic [1:0]         res_status;
    logic [FRAME_W-1:0] res_count;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    t_rx_scoreboard    sb;
    logic              tx_level;
    int                ones_run;
    int                bits_sent;
    bit                calm;
    bit                holding;
    event              hold_go;

    hdlc_nrzi_frame_receiver_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (line_valid),
        .o_in_ready     (in_ready),
        .i_line_bit     (line_bit),
        .o_out_valid    (out_valid),
        .i_out_ready    (res_ready),
        .o_kind         (res_kind),
        .o_data_byte    (res_byte),
        .o_frame_status (res_status),
        .o_frame_bytes  (res_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // The one long hold-off on the result side, so that the block backs up.
    initial begin
        holding = 1'b0;
        @(hold_go);
        @(posedge i_clk);
        holding <= 1'b1;
        repeat (300) @(posedge i_clk);
        holding <= 1'b0;
    end

    always @(posedge i_clk) begin
        res_ready <= !holding && (calm || $urandom_range(0, 99) >= 7);
    end

    always @(posedge i_clk) begin : observe
        t_result got;
        if (rst_n) begin
            if (out_valid && res_ready) begin
                got.kind         = res_kind;
                got.data_byte    = res_byte;
                got.frame_status = res_status;
                got.frame_bytes  = res_count;
                sb.check_result(got);
            end
            if (line_valid && in_ready) begin
                sb.take_line_bit(line_bit);
            end
        end
    end

    task automatic send_level(input logic level);
        if (!calm && $urandom_range(0, 99) < 7) begin
            line_valid <= 1'b0;
            @(posedge i_clk);
        end
        line_valid <= 1'b1;
        line_bit   <= level;
        do @(posedge i_clk); while (!in_ready);
        tx_level = level;
        bits_sent++;
    endtask

    // NRZI: a one keeps the line level, a zero toggles it.
    task automatic send_decoded(input logic d);
        send_level(d ? tx_level : ~tx_level);
    endtask

    task automatic send_data_bit(input logic d);
        send_decoded(d);
        ones_run = d ? ones_run + 1 : 0;
        if (ones_run == 5) begin
            send_decoded(1'b0);
            ones_run = 0;
        end
    endtask

    task automatic send_byte(input logic [7:0] value);
        for (int i = 0; i < 8; i++) begin
            send_data_bit(value[i]);
        end
    endtask

    task automatic send_flag();
        send_decoded(1'b0);
        repeat (6) send_decoded(1'b1);
        send_decoded(1'b0);
        ones_run = 0;
    endtask

    task automatic send_abort();
        send_decoded(1'b0);
        repeat (7) send_decoded(1'b1);
        ones_run = 0;
    endtask

    function automatic t_byte_q random_bytes(input int n);
        t_byte_q q;
        for (int i = 0; i < n; i++) begin
            q.push_back(8'($urandom));
        end
        return q;
    endfunction

    // Sends the payload after the previous flag, then the FCS and any odd tail bits
    // as the shape asks, then a closing flag (preceded by an abort for aborted frames).
    task automatic send_frame(input t_byte_q payload, input t_frame_shape shape);
        logic [15:0] crc;
        logic [15:0] fcs;
        crc = CRC_INIT;
        foreach (payload[i]) begin
            send_byte(payload[i]);
            crc = t_rx_scoreboard::crc_byte(crc, payload[i]);
        end
        fcs = ~crc;
        if (shape == SHAPE_BAD_FCS) begin
            fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
        end
        if (shape != SHAPE_NO_FCS && shape != SHAPE_ABORT) begin
            send_byte(fcs[7:0]);
            send_byte(fcs[15:8]);
        end
        if (shape == SHAPE_ODD_TAIL) begin
            repeat ($urandom_range(1, 7)) send_data_bit(1'($urandom_range(0, 1)));
        end
        if (shape == SHAPE_ABORT) begin
            send_abort();
        end
        send_flag();
    endtask

    task automatic write_register(input int index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(index * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_register(index, value);
    endtask

    task automatic settle();
        line_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly well-formed frames with random content, plus noise and flag runs.
    task automatic run_random(input int n_bits);
        int           stop_at;
        int           pick;
        t_frame_shape shape;
        stop_at = bits_sent + n_bits;
        while (bits_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    shape = SHAPE_GOOD;
                end else if (pick < 65) begin
                    shape = SHAPE_BAD_FCS;
                end else if (pick < 75) begin
                    shape = SHAPE_ODD_TAIL;
                end else if (pick < 88) begin
                    shape = SHAPE_NO_FCS;
                end else begin
                    shape = SHAPE_ABORT;
                end
                send_frame(random_bytes($urandom_range(0, 6)), shape);
            end else if (pick < 85) begin
                repeat ($urandom_range(4, 40)) send_level(1'($urandom_range(0, 1)));
                ones_run = 0;
                send_flag();
            end else begin
                repeat ($urandom_range(1, 3)) send_flag();
            end
        end
    endtask

    initial begin : stimulus
        t_byte_q payload;
        int      value;
        sb         = new();
        rst_n      = 1'b0;
        line_valid = 1'b0;
        line_bit   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        tx_level   = 1'b0;
        ones_run   = 0;
        bits_sent  = 0;
        calm       = 1'b0;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // An abort while searching is ignored; idle flags are silent.
        send_abort();
        repeat (3) send_flag();
        payload = {8'h00, 8'hFF, 8'h7E, 8'h7F, 8'hF8};
        send_frame(payload, SHAPE_GOOD);
        send_frame(random_bytes(3), SHAPE_BAD_FCS);
        send_frame(random_bytes(4), SHAPE_ODD_TAIL);
        send_frame(random_bytes(1), SHAPE_NO_FCS);
        send_frame(random_bytes(2), SHAPE_ABORT);
        // An abort right after a flag, with no bytes yet, gives nothing.
        send_abort();
        send_flag();
        // Oversized frame: bytes past the limit are dropped, frame discarded.
        send_frame(random_bytes(MAX_FRAME_BYTES + 6), SHAPE_NO_FCS);
        settle();

        // A write to an index with no register must leave the minimum alone.
        write_register(REG_UNUSED, 32'h0000_07FF);
        send_frame(random_bytes(1), SHAPE_GOOD);
        settle();

        write_register(REG_MIN_FRAME_BYTES, 32'd1);
        send_frame(random_bytes(1), SHAPE_NO_FCS);
        send_frame(random_bytes(0), SHAPE_GOOD);
        settle();

        write_register(REG_MIN_FRAME_BYTES, 32'd0);
        send_frame(random_bytes(0), SHAPE_GOOD);
        send_frame(random_bytes(0), SHAPE_NO_FCS);
        send_frame(random_bytes(0), SHAPE_ODD_TAIL);
        settle();

        // Longest checkable frame, sent with both sides running flat out.
        write_register(REG_MIN_FRAME_BYTES, 32'(MAX_FRAME_BYTES));
        calm = 1'b1;
        send_frame(random_bytes(MAX_FRAME_BYTES - 2), SHAPE_GOOD);
        calm = 1'b0;
        send_frame(random_bytes(3), SHAPE_GOOD);
        settle();

        // Above the frame limit every frame is discarded.
        write_register(REG_MIN_FRAME_BYTES, 32'hFFFF_FFFF);
        send_frame(random_bytes(5), SHAPE_GOOD);
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            value = (phase == 0) ? 3 : $urandom_range(0, 8);
            write_register(REG_MIN_FRAME_BYTES, ($urandom & 32'hFFFF_F800) | value);
            if (phase == 1) begin
                -> hold_go;
            end
            run_random(425);
            settle();
        end

        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
